// ----- design/status_led_blink_controller_defines.svh -----
// assertion macros for the status led blink controller
// used by slbc_core, the module that carries assertions; no other dependencies
`ifndef STATUS_LED_BLINK_CONTROLLER_DEFINES_SVH
`define STATUS_LED_BLINK_CONTROLLER_DEFINES_SVH

// condition and consequence in the same cycle
`define SLBC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("slbc check failed");

// consequence in the cycle after the condition
`define SLBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("slbc check failed");

`endif

// ----- design/slbc_pkg.sv -----
// types and constants shared by the status led blink controller
// no dependencies
package slbc_pkg;

    localparam int unsigned BLINK_W = 16;
    localparam int unsigned DUTY_W = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_INDEX_W = 1;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_RED_ONCE   = 2'd1,
        CMD_RED_TRIPLE = 2'd2,
        CMD_BLUE_ONCE  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLINK_TIME = 1'b0,
        CFG_DUTY_FLOOR = 1'b1
    } cfg_index_t;

    localparam logic [BLINK_W-1:0] BLINK_TIME_RESET = 16'd200;
    localparam logic [DUTY_W-1:0] DUTY_FLOOR_RESET = 8'd40;
    localparam logic [1:0] TRIPLE_COUNT = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic              error_flag;
        logic              auto_mode;
        logic [DUTY_W-1:0] fan_duty;
    } in_item_t;

    typedef struct packed {
        logic green_led;
        logic red_led;
        logic blue_led;
    } out_item_t;

    // input register contents handed to the core
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } stage_t;

endpackage

// ----- design/status_led_blink_controller.sv -----
// top level of the status led blink controller: config registers and stage wiring
// depends on slbc_pkg, slbc_in_stage and slbc_core
//
//  port group   dir   handshake          contents
//  s_           in    s_valid/s_ready    command, error_flag, auto_mode, fan_duty
//  m_           out   m_valid/m_ready    green_led, red_led, blue_led (ticks only)
//  cfg_         in    cfg_we             blink time (0), running duty floor (1)
//
// an item waits in the input register; a tick's result is valid the cycle after it advances
// one item per cycle when the result side keeps up
// the only stall is a tick reaching a full result register that is not being taken
// blink requests update the timers and never produce a result
// synchronous active-low reset clears timers, valid flags and config to defaults
module status_led_blink_controller import slbc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [BLINK_W-1:0] blink_time_reg;
    logic [DUTY_W-1:0]  duty_floor_reg;
    stage_t             stage;
    logic               advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_time_reg <= BLINK_TIME_RESET;
            duty_floor_reg <= DUTY_FLOOR_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_BLINK_TIME: blink_time_reg <= cfg_wdata[BLINK_W-1:0];
                CFG_DUTY_FLOOR: duty_floor_reg <= cfg_wdata[DUTY_W-1:0];
                default: begin
                    blink_time_reg <= blink_time_reg;
                end
            endcase
        end
    end

    slbc_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .advance (advance),
        .stage   (stage)
    );

    slbc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .stage      (stage),
        .advance    (advance),
        .blink_time (blink_time_reg),
        .duty_floor (duty_floor_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ----- design/slbc_in_stage.sv -----
// input register of the status led blink controller
// depends on slbc_pkg
module slbc_in_stage import slbc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     advance,
    output stage_t   stage
);

    logic     in_valid_reg;
    logic     in_valid_next;
    in_item_t item_reg;

    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign stage = {in_valid_reg, item_reg};

endmodule

// ----- design/slbc_core.sv -----
// blink timers, led decisions and result register
// depends on slbc_pkg and status_led_blink_controller_defines.svh
`include "status_led_blink_controller_defines.svh"

module slbc_core import slbc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  stage_t             stage,
    output logic               advance,
    input  logic [BLINK_W-1:0] blink_time,
    input  logic [DUTY_W-1:0]  duty_floor,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data
);

    logic [BLINK_W-1:0] red_single_reg, red_single_next;
    logic [BLINK_W-1:0] blue_single_reg, blue_single_next;
    logic [1:0]         blinks_left_reg, blinks_left_next;
    logic               phase_on_reg, phase_on_next;
    logic [BLINK_W-1:0] phase_left_reg, phase_left_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg;
    out_item_t          result;
    cmd_t               cmd;
    logic               is_tick;

    assign cmd     = cmd_t'(stage.item.command);
    assign is_tick = (cmd == CMD_TICK);
    // blink requests make no result, so only ticks wait on the result register
    assign advance = stage.valid && (!is_tick || !m_valid_reg || m_ready);

    always_comb begin
        logic [BLINK_W-1:0] rs;
        logic [BLINK_W-1:0] bs;
        logic [BLINK_W-1:0] pl;
        logic [1:0]         bl;
        logic               po;
        logic               err;
        rs  = red_single_reg;
        bs  = blue_single_reg;
        pl  = phase_left_reg;
        bl  = blinks_left_reg;
        po  = phase_on_reg;
        err = stage.item.error_flag;
        result = '0;
        case (cmd)
            CMD_RED_ONCE: begin
                rs = blink_time;
            end
            CMD_RED_TRIPLE: begin
                bl = TRIPLE_COUNT;
                po = 1'b1;
                pl = blink_time;
                rs = '0;
            end
            CMD_BLUE_ONCE: begin
                bs = blink_time;
            end
            CMD_TICK: begin
                result.green_led = !err && (stage.item.fan_duty >= duty_floor);
                if (err) begin
                    result.red_led = 1'b1;
                    rs = '0;
                    bl = '0;
                end else if (blinks_left_reg != 2'd0) begin
                    result.red_led = phase_on_reg;
                    if (phase_left_reg == '0) begin
                        if (phase_on_reg) begin
                            po = 1'b0;
                            pl = blink_time >> 1;
                        end else begin
                            bl = blinks_left_reg - 2'd1;
                            if (bl != 2'd0) begin
                                po = 1'b1;
                                pl = blink_time;
                            end
                        end
                    end
                end else if (red_single_reg != '0) begin
                    result.red_led = 1'b1;
                end
                if (!err && (blue_single_reg != '0)) begin
                    result.blue_led = 1'b1;
                end else begin
                    bs = '0;
                    result.blue_led = !err && stage.item.auto_mode;
                end
                // timers step down after the decisions, saturating at zero
                if (rs != '0) begin
                    rs = rs - BLINK_W'(1);
                end
                if (bs != '0) begin
                    bs = bs - BLINK_W'(1);
                end
                if (pl != '0) begin
                    pl = pl - BLINK_W'(1);
                end
            end
            default: begin
                result = '0;
            end
        endcase
        red_single_next  = rs;
        blue_single_next = bs;
        phase_left_next  = pl;
        blinks_left_next = bl;
        phase_on_next    = po;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && is_tick) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_single_reg  <= '0;
            blue_single_reg <= '0;
            blinks_left_reg <= '0;
            phase_on_reg    <= 1'b0;
            phase_left_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                red_single_reg  <= red_single_next;
                blue_single_reg <= blue_single_next;
                blinks_left_reg <= blinks_left_next;
                phase_on_reg    <= phase_on_next;
                phase_left_reg  <= phase_left_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && is_tick) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SLBC_ASSERT_NEXT(err_clears_timers, aclk, aresetn,
        advance && is_tick && stage.item.error_flag,
        red_single_reg == '0 && blue_single_reg == '0 && blinks_left_reg == 2'd0)
    `SLBC_ASSERT_NEXT(err_result_red_only, aclk, aresetn,
        advance && is_tick && stage.item.error_flag,
        m_valid && m_data.red_led && !m_data.green_led && !m_data.blue_led)
    `SLBC_ASSERT_NEXT(triple_loads, aclk, aresetn,
        advance && cmd == CMD_RED_TRIPLE,
        blinks_left_reg == TRIPLE_COUNT && phase_on_reg && red_single_reg == '0)

endmodule

// ----- tb/sv/status_led_blink_controller_tb.sv -----
// self-checking testbench for the status led blink controller
// depends on slbc_pkg and status_led_blink_controller; predicts led levels per tick item
module status_led_blink_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slbc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned QUIET_CYCLES = 4;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_BLINK_TIME;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // predictor state: config copy and blink timers
    logic [BLINK_W-1:0] blink_time_q    = BLINK_TIME_RESET;
    logic [DUTY_W-1:0]  duty_floor_q    = DUTY_FLOOR_RESET;
    logic [BLINK_W-1:0] red_once_ms     = '0;
    logic [BLINK_W-1:0] blue_once_ms    = '0;
    logic [BLINK_W-1:0] triple_phase_ms = '0;
    logic [1:0]         triple_left     = '0;
    logic               triple_on       = 1'b0;

    out_item_t   led_expect_q[$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    bit          idle_on     = 1'b1;

    status_led_blink_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [BLINK_W-1:0] count_down(input logic [BLINK_W-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction

    function automatic in_item_t make_item(input cmd_t cmd, input logic err,
                                           input logic auto_on, input logic [DUTY_W-1:0] duty);
        in_item_t it;
        it.command    = cmd;
        it.error_flag = err;
        it.auto_mode  = auto_on;
        it.fan_duty   = duty;
        return it;
    endfunction

    // blink requests only move timers; a tick reads them, then steps them down
    task automatic predict_leds(input in_item_t it);
        out_item_t leds;
        leds = '0;
        case (cmd_t'(it.command))
            CMD_RED_ONCE: begin
                red_once_ms = blink_time_q;
            end
            CMD_RED_TRIPLE: begin
                triple_left     = TRIPLE_COUNT;
                triple_on       = 1'b1;
                triple_phase_ms = blink_time_q;
                red_once_ms     = '0;
            end
            CMD_BLUE_ONCE: begin
                blue_once_ms = blink_time_q;
            end
            CMD_TICK: begin
                leds.green_led = !it.error_flag && (it.fan_duty >= duty_floor_q);
                if (it.error_flag) begin
                    leds.red_led = 1'b1;
                    red_once_ms  = '0;
                    triple_left  = '0;
                end else if (triple_left != '0) begin
                    // led shows the phase as it stood before any switch
                    leds.red_led = triple_on;
                    if (triple_phase_ms == '0) begin
                        if (triple_on) begin
                            triple_on       = 1'b0;
                            triple_phase_ms = blink_time_q >> 1;
                        end else begin
                            triple_left = triple_left - 1'b1;
                            if (triple_left != '0) begin
                                triple_on       = 1'b1;
                                triple_phase_ms = blink_time_q;
                            end
                        end
                    end
                end else if (red_once_ms != '0) begin
                    leds.red_led = 1'b1;
                end
                if (!it.error_flag && blue_once_ms != '0) begin
                    leds.blue_led = 1'b1;
                end else begin
                    blue_once_ms  = '0;
                    leds.blue_led = !it.error_flag && it.auto_mode;
                end
                red_once_ms     = count_down(red_once_ms);
                blue_once_ms    = count_down(blue_once_ms);
                triple_phase_ms = count_down(triple_phase_ms);
                led_expect_q.push_back(leds);
            end
            default: begin
            end
        endcase
    endtask

    // every call starts and ends just after a rising edge
    task automatic send_item(input in_item_t it);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_leds(it);
    endtask

    task automatic send_tick(input logic err, input logic auto_on,
                             input logic [DUTY_W-1:0] duty);
        send_item(make_item(CMD_TICK, err, auto_on, duty));
    endtask

    task automatic send_request(input cmd_t cmd);
        send_item(make_item(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255))));
    endtask

    // requests leave no result, so allow the pipeline to empty after the last tick
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (led_expect_q.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BLINK_TIME: blink_time_q = val[BLINK_W-1:0];
            CFG_DUTY_FLOOR: duty_floor_q = val[DUTY_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_config(input int unsigned blink, input int unsigned duty_floor);
        write_cfg(CFG_BLINK_TIME, blink[CFG_DATA_W-1:0]);
        write_cfg(CFG_DUTY_FLOOR, duty_floor[CFG_DATA_W-1:0]);
    endtask

    // result side: random stall bursts on m_ready
    initial begin : sink_ready
        int unsigned stall;
        forever begin
            @(posedge aclk);
            if (idle_on && aresetn && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 9);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : led_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (led_expect_q.size() == 0) begin
                $error("result item with no tick waiting: %b", m_data);
                fail_count++;
            end else begin
                want = led_expect_q.pop_front();
                if (m_data.green_led !== want.green_led) begin
                    $error("green_led expected %b actual %b", want.green_led, m_data.green_led);
                    fail_count++;
                end
                if (m_data.red_led !== want.red_led) begin
                    $error("red_led expected %b actual %b", want.red_led, m_data.red_led);
                    fail_count++;
                end
                if (m_data.blue_led !== want.blue_led) begin
                    $error("blue_led expected %b actual %b", want.blue_led, m_data.blue_led);
                    fail_count++;
                end
            end
        end
    end

    // reset values of both registers, green threshold at 40
    task automatic test_reset_defaults();
        send_tick(1'b0, 1'b0, 8'd0);
        send_tick(1'b0, 1'b1, 8'd39);
        send_tick(1'b0, 1'b1, 8'd40);
        send_tick(1'b1, 1'b1, 8'd255);
        send_request(CMD_RED_ONCE);
        send_tick(1'b0, 1'b0, 8'd255);
    endtask

    // full triple sequence at the shortest nonzero blink, blue blink alongside
    task automatic test_triple_blink();
        set_config(1, 0);
        send_request(CMD_RED_TRIPLE);
        send_request(CMD_BLUE_ONCE);
        for (int i = 0; i < 8; i++) send_tick(1'b0, i[0], 8'd0);
    endtask

    // an error tick drops every pending blink
    task automatic test_error_cancel();
        set_config(5, 128);
        send_request(CMD_RED_TRIPLE);
        send_request(CMD_BLUE_ONCE);
        send_tick(1'b0, 1'b0, 8'd128);
        send_tick(1'b1, 1'b1, 8'd127);
        send_tick(1'b0, 1'b0, 8'd127);
    endtask

    // zero blink time: single blinks never show, triple phases last one tick
    task automatic test_zero_blink_time();
        set_config(0, 255);
        send_request(CMD_RED_ONCE);
        send_request(CMD_BLUE_ONCE);
        send_request(CMD_RED_TRIPLE);
        for (int i = 0; i < 4; i++) send_tick(1'b0, 1'b1, 8'd255);
    endtask

    // mostly ticks with blink requests sprinkled in, rare errors
    task automatic run_random(input int unsigned n_items, input int unsigned blink,
                              input int unsigned duty_floor, input bit allow_idle);
        in_item_t    it;
        int unsigned pick;
        set_config(blink, duty_floor);
        idle_on = allow_idle && ($urandom_range(0, 3) != 0);
        for (int unsigned i = 0; i < n_items; i++) begin
            it   = make_item(CMD_TICK, $urandom_range(0, 19) == 0, 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)));
            pick = $urandom_range(0, 99);
            if (pick < 6)
                it.command = CMD_RED_ONCE;
            else if (pick < 12)
                it.command = CMD_RED_TRIPLE;
            else if (pick < 18)
                it.command = CMD_BLUE_ONCE;
            else if (pick < 21)
                it.command = 2'($urandom_range(0, 3));
            if (pick >= 21 && $urandom_range(0, 3) == 0)
                it.fan_duty = DUTY_W'(duty_floor + $urandom_range(0, 2) - 1);
            send_item(it);
        end
    endtask

    task automatic test_random_traffic();
        run_random(70, $urandom_range(1, 12), $urandom_range(0, 255), 1'b1);
        run_random(70, 1, 0, 1'b1);
        run_random(60, 65535, 255, 1'b1);
        run_random(70, $urandom_range(2, 30), $urandom_range(0, 60), 1'b1);
        run_random(70, 0, $urandom_range(0, 255), 1'b1);
        run_random(70, $urandom_range(1, 8), $urandom_range(0, 255), 1'b1);
        run_random(70, $urandom_range(1, 65535), $urandom_range(0, 255), 1'b1);
    endtask

    // closing stretch at full rate on both sides
    task automatic test_back_to_back();
        run_random(80, 3, 40, 1'b0);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_triple_blink();
        test_error_cancel();
        test_zero_blink_time();
        test_random_traffic();
        test_back_to_back();
        s_valid <= 1'b0;
        while (led_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
